### rtl/core/afr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package afr_pkg;

  typedef enum logic [1:0] {
    ALIGN_NEAR   = 2'd0,
    ALIGN_CENTER = 2'd1,
    ALIGN_FAR    = 2'd2
  } afr_align_e;

endpackage

`default_nettype wire

### rtl/core/afr_div.sv
`timescale 1ns / 1ps
`default_nettype none

module afr_div #(
  parameter int unsigned COORD_BITS = 12,
  parameter int unsigned SIDE_BITS  = 79
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [2*COORD_BITS+1:0] num_i,
  input  wire logic [COORD_BITS:0]     den_i,
  input  wire logic [SIDE_BITS-1:0]    side_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [COORD_BITS-1:0]        quo_o,
  output logic [SIDE_BITS-1:0]         side_o
);

  localparam int unsigned N     = COORD_BITS;
  localparam int unsigned NUM_W = 2 * COORD_BITS + 2;

  logic                 valid_q [N];
  logic [NUM_W-1:0]     rem_q   [N];
  logic [N:0]           den_q   [N];
  logic [N-1:0]         quo_q   [N];
  logic [SIDE_BITS-1:0] side_q  [N];
  logic [N:0]           ready;

  assign ready[N] = out_ready_i;

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int unsigned Shift = N - 1 - k;

    logic                 v_in;
    logic [NUM_W-1:0]     r_in;
    logic [N:0]           d_in;
    logic [N-1:0]         q_in;
    logic [SIDE_BITS-1:0] s_in;
    logic [NUM_W:0]       diff;
    logic                 q_bit;
    logic [NUM_W-1:0]     rem_d;
    logic [N-1:0]         quo_d;

    if (k == 0) begin : g_first
      assign v_in = in_valid_i;
      assign r_in = num_i;
      assign d_in = den_i;
      assign q_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = valid_q[k-1];
      assign r_in = rem_q[k-1];
      assign d_in = den_q[k-1];
      assign q_in = quo_q[k-1];
      assign s_in = side_q[k-1];
    end

    // trial subtract of the shifted divisor, one quotient bit per stage
    assign diff  = {1'b0, r_in} - {1'b0, (NUM_W'(d_in) << Shift)};
    assign q_bit = ~diff[NUM_W];
    assign rem_d = q_bit ? diff[NUM_W-1:0] : r_in;
    assign quo_d = {q_in[N-2:0], q_bit};

    assign ready[k] = ~valid_q[k] | ready[k+1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (ready[k]) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ready[k] && v_in) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= d_in;
        quo_q[k]  <= quo_d;
        side_q[k] <= s_in;
      end
    end
  end

  assign in_ready_o  = ready[0];
  assign out_valid_o = valid_q[N-1];
  assign quo_o       = quo_q[N-1];
  assign side_o      = side_q[N-1];

endmodule

`default_nettype wire

### rtl/core/aspect_fit_rect_align.sv
`timescale 1ns / 1ps
`default_nettype none

// Fits a rectangle into a bounding box keeping its aspect ratio, with half-up rational
// rounding, and places it by horizontal and vertical alignment. One request is taken
// every cycle while in_stall_o is low, and each request passes through registers for the
// two products, the fit decision, the restoring divider that retires one quotient bit
// per stage, and placement. An empty box or rectangle returns fit_valid low, zero
// position and the rectangle size unchanged.
module aspect_fit_rect_align #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic [COORD_BITS-1:0]        bounds_left_i,
  input  wire logic [COORD_BITS-1:0]        bounds_top_i,
  input  wire logic [COORD_BITS-1:0]        bounds_width_i,
  input  wire logic [COORD_BITS-1:0]        bounds_height_i,
  input  wire logic [COORD_BITS-1:0]        rect_width_i,
  input  wire logic [COORD_BITS-1:0]        rect_height_i,
  input  wire logic [1:0]                   h_align_i,
  input  wire logic [1:0]                   v_align_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic                              fit_valid_o,
  output logic signed [COORD_BITS+1:0]      out_left_o,
  output logic signed [COORD_BITS+1:0]      out_top_o,
  output logic [COORD_BITS-1:0]             out_width_o,
  output logic [COORD_BITS-1:0]             out_height_o
);

  localparam int unsigned N     = COORD_BITS;
  localparam int unsigned NUM_W = 2 * COORD_BITS + 2;
  localparam int unsigned POS_W = COORD_BITS + 2;

  typedef struct packed {
    logic         empty;
    logic         shrink;
    logic         tall;
    logic [N-1:0] bl;
    logic [N-1:0] bt;
    logic [N-1:0] bw;
    logic [N-1:0] bh;
    logic [N-1:0] rw;
    logic [N-1:0] rh;
    logic [1:0]   ha;
    logic [1:0]   va;
  } side_t;

  localparam int unsigned SIDE_BITS = $bits(side_t);

  function automatic logic [POS_W-1:0] place(logic [N-1:0] edge_pos, logic [N-1:0] box,
                                             logic [N-1:0] size, logic [1:0] align);
    logic [N:0] slack;
    logic [POS_W-1:0] pos;
    slack = {1'b0, box} - {1'b0, size} + (N+1)'(1);
    unique case (align)
      afr_pkg::ALIGN_CENTER: pos = POS_W'(edge_pos) + POS_W'(slack >> 1);
      afr_pkg::ALIGN_FAR:    pos = POS_W'(edge_pos) + POS_W'(box) - POS_W'(1) - POS_W'(size);
      default:               pos = POS_W'(edge_pos);
    endcase
    return pos;
  endfunction

  // handshake chain
  logic out_valid_q;
  logic s1_valid_q, s2_valid_q;
  logic r_out, r_div, r2, r1;
  logic div_out_valid;

  assign r_out      = ~out_valid_q | ~out_stall_i;
  assign r2         = ~s2_valid_q | r_div;
  assign r1         = ~s1_valid_q | r2;
  assign in_stall_o = ~r1;

  // stage 1: products
  side_t          s1_side_d, s1_side_q;
  logic [2*N-1:0] s1_pa_q, s1_pb_q;
  logic [2*N-1:0] s1_pa_d, s1_pb_d;

  always_comb begin
    s1_side_d        = '0;
    s1_side_d.bl     = bounds_left_i;
    s1_side_d.bt     = bounds_top_i;
    s1_side_d.bw     = bounds_width_i;
    s1_side_d.bh     = bounds_height_i;
    s1_side_d.rw     = rect_width_i;
    s1_side_d.rh     = rect_height_i;
    s1_side_d.ha     = h_align_i;
    s1_side_d.va     = v_align_i;
    s1_side_d.empty  = (bounds_width_i == '0) | (bounds_height_i == '0) |
                       (rect_width_i == '0) | (rect_height_i == '0);
    s1_side_d.shrink = (rect_width_i > bounds_width_i) | (rect_height_i > bounds_height_i);
    s1_pa_d          = rect_height_i * bounds_width_i;
    s1_pb_d          = rect_width_i * bounds_height_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (r1) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1 && in_valid_i) begin
      s1_side_q <= s1_side_d;
      s1_pa_q   <= s1_pa_d;
      s1_pb_q   <= s1_pb_d;
    end
  end

  // stage 2: width-first height too tall, pick divider operands
  side_t            s2_side_d, s2_side_q;
  logic [NUM_W-1:0] s2_num_d, s2_num_q;
  logic [N:0]       s2_den_d, s2_den_q;
  logic [NUM_W-1:0] two_pa, two_pb;

  assign two_pa = {1'b0, s1_pa_q, 1'b0};
  assign two_pb = {1'b0, s1_pb_q, 1'b0};

  always_comb begin
    s2_side_d      = s1_side_q;
    s2_side_d.tall = two_pa >= (two_pb + NUM_W'(s1_side_q.rw));
    if (s2_side_d.tall) begin
      s2_num_d = two_pb + NUM_W'(s1_side_q.rh);
      s2_den_d = {s1_side_q.rh, 1'b0};
    end else begin
      s2_num_d = two_pa + NUM_W'(s1_side_q.rw);
      s2_den_d = {s1_side_q.rw, 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (r2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r2 && s1_valid_q) begin
      s2_side_q <= s2_side_d;
      s2_num_q  <= s2_num_d;
      s2_den_q  <= s2_den_d;
    end
  end

  // divider pipeline
  logic [N-1:0]         div_quo;
  logic [SIDE_BITS-1:0] div_side_bits;
  side_t                div_side;

  afr_div #(
    .COORD_BITS(COORD_BITS),
    .SIDE_BITS (SIDE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s2_valid_q),
    .in_ready_o (r_div),
    .num_i      (s2_num_q),
    .den_i      (s2_den_q),
    .side_i     (s2_side_q),
    .out_valid_o(div_out_valid),
    .out_ready_i(r_out),
    .quo_o      (div_quo),
    .side_o     (div_side_bits)
  );

  assign div_side = side_t'(div_side_bits);

  // output stage: size selection and placement
  logic             fit_d, fit_q;
  logic [POS_W-1:0] left_d, left_q, top_d, top_q;
  logic [N-1:0]     w_d, w_q, h_d, h_q;

  always_comb begin
    w_d = div_side.rw;
    h_d = div_side.rh;
    if (div_side.shrink) begin
      if (div_side.tall) begin
        w_d = div_quo;
        h_d = div_side.bh;
      end else begin
        w_d = div_side.bw;
        h_d = div_quo;
      end
    end
    fit_d  = ~div_side.empty;
    left_d = place(div_side.bl, div_side.bw, w_d, div_side.ha);
    top_d  = place(div_side.bt, div_side.bh, h_d, div_side.va);
    if (div_side.empty) begin
      w_d    = div_side.rw;
      h_d    = div_side.rh;
      left_d = '0;
      top_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (r_out) begin
      out_valid_q <= div_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_out && div_out_valid) begin
      fit_q  <= fit_d;
      left_q <= left_d;
      top_q  <= top_d;
      w_q    <= w_d;
      h_q    <= h_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign fit_valid_o  = fit_q;
  assign out_left_o   = signed'(left_q);
  assign out_top_o    = signed'(top_q);
  assign out_width_o  = w_q;
  assign out_height_o = h_q;

endmodule

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned W         = 12;
  localparam int unsigned EXP_DEPTH = 64;

  typedef struct packed {
    logic [W-1:0] box_l;
    logic [W-1:0] box_t;
    logic [W-1:0] box_w;
    logic [W-1:0] box_h;
    logic [W-1:0] rect_w;
    logic [W-1:0] rect_h;
    logic [1:0]   h_align;
    logic [1:0]   v_align;
  } fit_req_t;

  typedef struct packed {
    logic                fit_valid;
    logic signed [W+1:0] left;
    logic signed [W+1:0] top;
    logic [W-1:0]        width;
    logic [W-1:0]        height;
  } fit_res_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [W-1:0]        bounds_left_i;
  logic [W-1:0]        bounds_top_i;
  logic [W-1:0]        bounds_width_i;
  logic [W-1:0]        bounds_height_i;
  logic [W-1:0]        rect_width_i;
  logic [W-1:0]        rect_height_i;
  logic [1:0]          h_align_i;
  logic [1:0]          v_align_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                fit_valid_o;
  logic signed [W+1:0] out_left_o;
  logic signed [W+1:0] out_top_o;
  logic [W-1:0]        out_width_o;
  logic [W-1:0]        out_height_o;

  fit_res_t expected_fits [EXP_DEPTH];
  int       sent_count;
  int       mismatch_count;
  int       result_idx;
  bit       quiet;

  aspect_fit_rect_align #(
    .COORD_BITS(W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .bounds_left_i  (bounds_left_i),
    .bounds_top_i   (bounds_top_i),
    .bounds_width_i (bounds_width_i),
    .bounds_height_i(bounds_height_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .h_align_i      (h_align_i),
    .v_align_i      (v_align_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .fit_valid_o    (fit_valid_o),
    .out_left_o     (out_left_o),
    .out_top_o      (out_top_o),
    .out_width_o    (out_width_o),
    .out_height_o   (out_height_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint unsigned round_half_up(longint unsigned num,
                                                    longint unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic logic signed [W+1:0] place_axis(logic [W-1:0] edge_pos,
                                                     logic [W-1:0] box_size,
                                                     longint unsigned fit_size,
                                                     logic [1:0] align);
    longint e;
    longint b;
    longint s;
    e = longint'(edge_pos);
    b = longint'(box_size);
    s = longint'(fit_size);
    if (align == afr_pkg::ALIGN_CENTER) begin
      return (W+2)'(e + (b - s + 1) / 2);
    end
    if (align == afr_pkg::ALIGN_FAR) begin
      return (W+2)'(e + b - 1 - s);
    end
    return (W+2)'(e);
  endfunction

  function automatic fit_res_t predict_fit(fit_req_t r);
    fit_res_t        res;
    longint unsigned w;
    longint unsigned h;
    longint unsigned th;
    res = '0;
    if (r.box_w == 0 || r.box_h == 0 || r.rect_w == 0 || r.rect_h == 0) begin
      res.width  = r.rect_w;
      res.height = r.rect_h;
      return res;
    end
    w = r.rect_w;
    h = r.rect_h;
    if (r.rect_w > r.box_w || r.rect_h > r.box_h) begin
      th = round_half_up(h * r.box_w, w);
      if (th > r.box_h) begin
        w = round_half_up(longint'(r.rect_w) * r.box_h, h);
        h = r.box_h;
      end else begin
        w = r.box_w;
        h = th;
      end
    end
    res.fit_valid = 1'b1;
    res.left      = place_axis(r.box_l, r.box_w, w, r.h_align);
    res.top       = place_axis(r.box_t, r.box_h, h, r.v_align);
    res.width     = w[W-1:0];
    res.height    = h[W-1:0];
    return res;
  endfunction

  function automatic fit_req_t make_req(int bl, int bt, int bw, int bh, int rw, int rh,
                                        logic [1:0] ha, logic [1:0] va);
    fit_req_t r;
    r.box_l   = W'(bl);
    r.box_t   = W'(bt);
    r.box_w   = W'(bw);
    r.box_h   = W'(bh);
    r.rect_w  = W'(rw);
    r.rect_h  = W'(rh);
    r.h_align = ha;
    r.v_align = va;
    return r;
  endfunction

  function automatic fit_req_t rand_fit_req();
    fit_req_t r;
    int       kind;
    kind      = int'($urandom_range(99));
    r.box_l   = W'($urandom_range(4095));
    r.box_t   = W'($urandom_range(4095));
    r.box_w   = W'($urandom_range(4095, 1));
    r.box_h   = W'($urandom_range(4095, 1));
    r.rect_w  = W'($urandom_range(4095, 1));
    r.rect_h  = W'($urandom_range(4095, 1));
    r.h_align = 2'($urandom_range(3));
    r.v_align = 2'($urandom_range(3));
    if (kind < 6) begin
      case ($urandom_range(3))
        0: r.box_w = '0;
        1: r.box_h = '0;
        2: r.rect_w = '0;
        default: r.rect_h = '0;
      endcase
    end else if (kind < 26) begin
      r.box_w  = W'($urandom_range(16, 1));
      r.box_h  = W'($urandom_range(16, 1));
      r.rect_w = W'($urandom_range(16, 1));
      r.rect_h = W'($urandom_range(16, 1));
    end else if (kind < 46) begin
      r.rect_w = W'($urandom_range(r.box_w, 1));
      r.rect_h = W'($urandom_range(r.box_h, 1));
    end else if (kind < 51) begin
      r.rect_w = r.box_w;
      r.rect_h = r.box_h;
    end else if (kind < 58) begin
      if ($urandom_range(1)) r.rect_w = W'($urandom_range(3, 1));
      else r.rect_h = W'($urandom_range(3, 1));
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch at result %0d: %s expected %0d got %0d", result_idx, what, want, got);
    mismatch_count++;
  endtask

  task automatic send_fit(input fit_req_t r);
    if (!quiet) begin
      while ($urandom_range(99) < 31) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    bounds_left_i   <= r.box_l;
    bounds_top_i    <= r.box_t;
    bounds_width_i  <= r.box_w;
    bounds_height_i <= r.box_h;
    rect_width_i    <= r.rect_w;
    rect_height_i   <= r.rect_h;
    h_align_i       <= r.h_align;
    v_align_i       <= r.v_align;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_fits[sent_count % EXP_DEPTH] = predict_fit(r);
    sent_count++;
  endtask

  always @(posedge clk_i) begin
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 31);
  end

  always @(posedge clk_i) begin : check_results
    fit_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (result_idx >= sent_count) begin
        report_mismatch("unexpected result, width", 0, out_width_o);
      end else begin
        want = expected_fits[result_idx % EXP_DEPTH];
        if (fit_valid_o !== want.fit_valid)
          report_mismatch("fit_valid", want.fit_valid, fit_valid_o);
        if (out_left_o !== want.left) report_mismatch("out_left", want.left, out_left_o);
        if (out_top_o !== want.top) report_mismatch("out_top", want.top, out_top_o);
        if (out_width_o !== want.width)
          report_mismatch("out_width", want.width, out_width_o);
        if (out_height_o !== want.height)
          report_mismatch("out_height", want.height, out_height_o);
      end
      result_idx++;
    end
  end

  task automatic test_empty_inputs();
    send_fit(make_req(4095, 4095, 0, 4095, 4095, 4095,
                      afr_pkg::ALIGN_FAR, afr_pkg::ALIGN_FAR));
    send_fit(make_req(4095, 4095, 4095, 0, 4095, 4095,
                      afr_pkg::ALIGN_CENTER, afr_pkg::ALIGN_CENTER));
    send_fit(make_req(100, 200, 4095, 4095, 0, 4095,
                      afr_pkg::ALIGN_FAR, afr_pkg::ALIGN_NEAR));
    send_fit(make_req(100, 200, 4095, 4095, 4095, 0,
                      afr_pkg::ALIGN_NEAR, afr_pkg::ALIGN_FAR));
    send_fit(make_req(0, 0, 0, 0, 0, 0, afr_pkg::ALIGN_NEAR, afr_pkg::ALIGN_NEAR));
  endtask

  task automatic test_fit_inside();
    // rectangle fills a box at the origin, far edge lands on -1
    send_fit(make_req(0, 0, 4095, 4095, 4095, 4095, afr_pkg::ALIGN_FAR, afr_pkg::ALIGN_FAR));
    send_fit(make_req(4095, 4095, 4095, 4095, 1, 1, afr_pkg::ALIGN_FAR, afr_pkg::ALIGN_FAR));
    send_fit(make_req(4095, 4095, 4095, 4095, 4094, 4094,
                      afr_pkg::ALIGN_CENTER, afr_pkg::ALIGN_CENTER));
    send_fit(make_req(10, 20, 9, 8, 4, 3, afr_pkg::ALIGN_CENTER, afr_pkg::ALIGN_FAR));
  endtask

  task automatic test_shrink_rounding();
    // thin rectangles round down to zero
    send_fit(make_req(0, 0, 1, 4095, 4095, 1, afr_pkg::ALIGN_CENTER, afr_pkg::ALIGN_CENTER));
    send_fit(make_req(0, 0, 4095, 1, 1, 4095, afr_pkg::ALIGN_FAR, afr_pkg::ALIGN_FAR));
    // half-way quotients round up, an exact quotient stays
    send_fit(make_req(5, 5, 3, 100, 4, 2, afr_pkg::ALIGN_NEAR, afr_pkg::ALIGN_FAR));
    send_fit(make_req(5, 5, 100, 3, 2, 4, afr_pkg::ALIGN_FAR, afr_pkg::ALIGN_NEAR));
    send_fit(make_req(4095, 4095, 4095, 2048, 4095, 4095,
                      afr_pkg::ALIGN_CENTER, afr_pkg::ALIGN_FAR));
  endtask

  task automatic test_alignment_codes();
    send_fit(make_req(300, 400, 101, 77, 40, 30, afr_pkg::ALIGN_NEAR, afr_pkg::ALIGN_NEAR));
    send_fit(make_req(300, 400, 101, 77, 40, 30,
                      afr_pkg::ALIGN_CENTER, afr_pkg::ALIGN_CENTER));
    send_fit(make_req(300, 400, 101, 77, 40, 30, afr_pkg::ALIGN_FAR, afr_pkg::ALIGN_FAR));
    send_fit(make_req(300, 400, 101, 77, 40, 30, 2'd3, 2'd3));
    send_fit(make_req(300, 400, 101, 77, 40, 30, afr_pkg::ALIGN_CENTER, afr_pkg::ALIGN_FAR));
    send_fit(make_req(300, 400, 101, 77, 40, 30, afr_pkg::ALIGN_FAR, afr_pkg::ALIGN_CENTER));
  endtask

  task automatic test_random_traffic(int n);
    repeat (n) send_fit(rand_fit_req());
  endtask

  task automatic test_back_to_back(int n);
    quiet = 1'b1;
    repeat (n) send_fit(rand_fit_req());
    quiet = 1'b0;
  endtask

  initial begin
    mismatch_count  = 0;
    result_idx      = 0;
    sent_count      = 0;
    quiet           = 1'b0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    bounds_left_i   <= '0;
    bounds_top_i    <= '0;
    bounds_width_i  <= '0;
    bounds_height_i <= '0;
    rect_width_i    <= '0;
    rect_height_i   <= '0;
    h_align_i       <= '0;
    v_align_i       <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_inputs();
    test_fit_inside();
    test_shrink_rounding();
    test_alignment_codes();
    test_random_traffic(400);
    test_back_to_back(200);
    test_random_traffic(200);
    in_valid_i <= 1'b0;
    while (result_idx < sent_count) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

### filelist.f
rtl/core/afr_pkg.sv
rtl/core/afr_div.sv
rtl/core/aspect_fit_rect_align.sv
sim/tb_top.sv
